### design/run_length_range_table_core_assert.svh
`ifndef RUN_LENGTH_RANGE_TABLE_CORE_ASSERT_SVH
`define RUN_LENGTH_RANGE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RLRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RLRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rlrt_pkg.sv
package rlrt_pkg;

  localparam int POS_BITS     = 20;
  localparam int VALUE_BITS   = 16;
  localparam int SUM_BITS     = 32;
  localparam int COUNT_BITS   = 21;
  localparam int INDEX_BITS   = 8;
  localparam int STATUS_BITS  = 2;
  localparam int OP_BITS      = 3;
  localparam int MAX_RUNS_DEF = 256;

  localparam logic [OP_BITS-1:0] OP_SET    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_READ   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SUM    = 3'd4;
  localparam logic [OP_BITS-1:0] OP_COUNT  = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]    opcode;
    logic [POS_BITS-1:0]   start_pos;
    logic [POS_BITS-1:0]   end_pos;
    logic [POS_BITS-1:0]   shift_count;
    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] match_mask;
    logic [VALUE_BITS-1:0] match_compare;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  read_value;
    logic [INDEX_BITS-1:0]  run_index;
    logic [SUM_BITS-1:0]    range_sum;
    logic [COUNT_BITS-1:0]  match_count;
    logic [STATUS_BITS-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic ph_a;
    logic ph_b;
    logic ph_c;
    logic finish;
  } rlrt_cmd_t;

  typedef struct packed {
    logic skip;
    logic last_run;
  } rlrt_sts_t;

endpackage

### design/rlrt_ctrl.sv
module rlrt_ctrl import rlrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  rlrt_sts_t sts,
  output rlrt_cmd_t cmd,
  output logic      busy,
  output logic      out_strobe
);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_PA, S_PB, S_PC, S_FLUSH} state_t;

  state_t state_r, state_nxt;
  logic   strobe_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_PREP;
      S_PREP:  state_nxt = sts.skip ? S_FLUSH : S_PA;
      S_PA:    state_nxt = S_PB;
      S_PB:    state_nxt = S_PC;
      S_PC:    state_nxt = sts.last_run ? S_FLUSH : S_PA;
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.prep   = (state_r == S_PREP);
    cmd.ph_a   = (state_r == S_PA);
    cmd.ph_b   = (state_r == S_PB);
    cmd.ph_c   = (state_r == S_PC);
    cmd.finish = (state_r == S_FLUSH);
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_FLUSH);
    end
  end

endmodule

### design/rlrt_dp.sv
module rlrt_dp import rlrt_pkg::*; #(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rlrt_cmd_t           cmd,
  output rlrt_sts_t           sts,
  input  in_item_t            in_item,
  input  logic                cfg_we,
  input  logic [POS_BITS-1:0] cfg_wdata,
  output out_item_t           out_item
);

  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int CNT_W = $clog2(MAX_RUNS + 3);
  localparam int ADR_W = IDX_W + 1;
  localparam int DEPTH = 2 ** ADR_W;
  localparam int PW    = POS_BITS;
  localparam int PW1   = POS_BITS + 1;
  localparam int PRODW = VALUE_BITS + PW1;

  typedef struct packed {
    logic [PW-1:0]         e;
    logic [VALUE_BITS-1:0] v;
  } entry_t;

  // two banks: bank_r is live, writers stream into the other one and swap
  entry_t mem_q [0:DEPTH-1];
  entry_t rd_q;

  logic [PW-1:0]          last_pos_r;
  logic                   bank_r;
  logic [CNT_W-1:0]       total_r;

  logic [OP_BITS-1:0]     op_r;
  logic [PW-1:0]          start_r, hi_r, shift_r, top_r;
  logic [PW1-1:0]         len2_r;
  logic [VALUE_BITS-1:0]  val_r, mask_r, cmp_r;
  logic                   tail_r, skip_r, modify_r;
  logic [STATUS_BITS-1:0] st_r;

  logic [IDX_W-1:0]       ent_idx_r;
  logic [PW1-1:0]         beg_r;
  logic                   hit_r, stop_r, bdone_r;

  logic [PW-1:0]          pend_e_r;
  logic [VALUE_BITS-1:0]  pend_v_r;
  logic                   pend_vld_r;
  logic [CNT_W-1:0]       wr_cnt_r;

  logic [PRODW-1:0]       prod_r;
  logic [SUM_BITS-1:0]    acc_r;
  logic [COUNT_BITS-1:0]  mc_r;
  logic [VALUE_BITS-1:0]  rv_r;
  logic [IDX_W-1:0]       ri_r;
  out_item_t              out_r;

  // ---- item decode
  logic                   d_skip, d_modify, d_tail;
  logic [STATUS_BITS-1:0] d_st;
  logic [PW-1:0]          d_hi, d_shift, d_top;
  logic [PW1-1:0]         d_len2, d_s2;
  logic [PW+1:0]          rm_sum;
  logic                   bad_order;

  always_comb begin
    bad_order = in_item.start_pos > in_item.end_pos;
    rm_sum    = (PW+2)'(in_item.start_pos) + (PW+2)'(in_item.shift_count);
    d_top     = (in_item.end_pos < last_pos_r) ? in_item.end_pos : last_pos_r;
    d_s2      = (in_item.start_pos > last_pos_r) ? PW1'(in_item.start_pos)
                                                 : PW1'(last_pos_r) + PW1'(1);
    d_len2    = (in_item.end_pos > last_pos_r)
                ? PW1'(in_item.end_pos) - d_s2 + PW1'(1) : '0;
    d_skip    = 1'b0;
    d_modify  = 1'b0;
    d_tail    = 1'b0;
    d_st      = ST_OK;
    d_hi      = in_item.end_pos;
    d_shift   = '0;
    unique case (in_item.opcode)
      OP_SET: begin
        d_modify = 1'b1;
        if (bad_order || in_item.end_pos > last_pos_r) begin
          d_skip = 1'b1;
          d_st   = ST_BAD;
        end
      end
      OP_READ: begin
      end
      OP_INSERT: begin
        d_modify = 1'b1;
        d_shift  = in_item.shift_count;
      end
      OP_REMOVE: begin
        d_modify = 1'b1;
        d_shift  = in_item.shift_count;
        // range reaching the last position keeps the run holding start_pos
        d_tail   = rm_sum > (PW+2)'(last_pos_r);
        d_hi     = PW'(rm_sum - (PW+2)'(1));
        if (in_item.start_pos > last_pos_r) begin
          d_skip = 1'b1;
          d_st   = ST_BAD;
        end else if (in_item.shift_count == '0) begin
          d_skip = 1'b1;
        end
      end
      OP_SUM, OP_COUNT: begin
        if (bad_order) begin
          d_skip = 1'b1;
          d_st   = ST_BAD;
        end
      end
      default: begin
        d_skip = 1'b1;
        d_st   = ST_BAD;
      end
    endcase
  end

  // ---- per-run terms
  logic [PW-1:0]         ent_e, start_m1, pre_end, ov_hi;
  logic [VALUE_BITS-1:0] ent_v;
  logic [PW1-1:0]        ent_e1, start_w, ov_lo, len1, ins_e2;
  logic                  last_run, b_lt_s, ins_shift, ins_clamp, read_hit, val_match;

  always_comb begin
    ent_e     = rd_q.e;
    ent_v     = rd_q.v;
    ent_e1    = PW1'(ent_e) + PW1'(1);
    start_w   = PW1'(start_r);
    start_m1  = start_r - PW'(1);
    last_run  = (ent_idx_r == IDX_W'(total_r - CNT_W'(1)));
    b_lt_s    = beg_r < start_w;
    pre_end   = (ent_e < start_m1) ? ent_e : start_m1;
    ov_lo     = (beg_r > start_w) ? beg_r : start_w;
    ov_hi     = (ent_e < top_r) ? ent_e : top_r;
    len1      = (PW1'(ov_hi) >= ov_lo) ? PW1'(ov_hi) - ov_lo + PW1'(1) : '0;
    val_match = (ent_v & mask_r) == cmp_r;
    ins_shift = (ent_e1 >= start_w) || last_run;
    ins_e2    = ins_shift ? PW1'(ent_e) + PW1'(shift_r) : PW1'(ent_e);
    ins_clamp = ins_e2 >= PW1'(last_pos_r);
    read_hit  = (ent_e >= start_r) || last_run;
  end

  assign sts.skip     = skip_r;
  assign sts.last_run = last_run;

  // ---- push requests toward the new table
  logic                  push_en, set_b_push;
  logic [PW-1:0]         push_e;
  logic [VALUE_BITS-1:0] push_v;

  always_comb begin
    push_en    = 1'b0;
    push_e     = ent_e;
    push_v     = ent_v;
    set_b_push = 1'b0;
    if (cmd.ph_a) begin
      case (op_r)
        OP_SET, OP_REMOVE: begin
          if (b_lt_s) begin
            push_en = 1'b1;
            push_e  = pre_end;
          end
        end
        OP_INSERT: begin
          if (!stop_r) begin
            push_en = 1'b1;
            push_e  = ins_clamp ? last_pos_r : PW'(ins_e2);
          end
        end
        default: push_en = 1'b0;
      endcase
    end else if (cmd.ph_b) begin
      case (op_r)
        OP_SET: begin
          if (!bdone_r && ent_e1 >= start_w) begin
            push_en    = 1'b1;
            set_b_push = 1'b1;
            push_e     = hi_r;
            push_v     = val_r;
          end
        end
        OP_REMOVE: begin
          if (tail_r && ent_e >= start_r && !(beg_r > start_w)) begin
            push_en = 1'b1;
            push_e  = last_pos_r;
          end
        end
        default: push_en = 1'b0;
      endcase
    end else if (cmd.ph_c) begin
      case (op_r)
        OP_SET, OP_REMOVE: begin
          if (!tail_r && ent_e > hi_r) begin
            push_en = 1'b1;
            push_e  = last_run ? last_pos_r : ent_e - shift_r;
          end
        end
        default: push_en = 1'b0;
      endcase
    end
  end

  // ---- merge and write
  logic                  merge, push_wr, flush_wr, room;
  logic [CNT_W-1:0]      new_total;
  logic                  overflow, commit;
  logic                  mem_we;
  logic [ADR_W-1:0]      mem_wa, rd_a;
  entry_t                mem_wd;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_idx;
  logic [STATUS_BITS-1:0] fin_st;

  always_comb begin
    merge     = pend_vld_r && (pend_v_r == push_v);
    push_wr   = push_en && pend_vld_r && !merge;
    flush_wr  = cmd.finish && pend_vld_r;
    room      = wr_cnt_r < CNT_W'(MAX_RUNS);
    new_total = wr_cnt_r + CNT_W'(pend_vld_r);
    overflow  = new_total > CNT_W'(MAX_RUNS);
    commit    = modify_r && !skip_r && !((op_r == OP_SET) && overflow);
    fin_st    = ((op_r == OP_SET) && !skip_r && overflow) ? ST_FULL : st_r;

    if (!rst_n || cfg_we) begin
      // table clear: one zero run ending at the last position
      mem_we   = 1'b1;
      mem_wa   = '0;
      mem_wd.e = rst_n ? cfg_wdata : '1;
      mem_wd.v = '0;
    end else begin
      mem_we   = (push_wr || flush_wr) && room;
      mem_wa   = {~bank_r, wr_cnt_r[IDX_W-1:0]};
      mem_wd.e = pend_e_r;
      mem_wd.v = pend_v_r;
    end

    rd_en  = cmd.prep || (cmd.ph_c && !last_run);
    rd_idx = cmd.prep ? '0 : ent_idx_r + IDX_W'(1);
    rd_a   = {bank_r, rd_idx};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_a];
    end
  end

  // ---- arithmetic
  logic [PW1-1:0]   mul_len;
  logic [PRODW:0]   sum_wide;
  logic [SUM_BITS-1:0] acc_nxt;

  always_comb begin
    mul_len  = cmd.ph_a ? len1 : (last_run ? len2_r : '0);
    sum_wide = (PRODW+1)'(acc_r) + (PRODW+1)'(prod_r);
    acc_nxt  = (sum_wide[PRODW:SUM_BITS] != '0) ? '1 : sum_wide[SUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '1;
      bank_r     <= 1'b0;
      total_r    <= CNT_W'(1);
      skip_r     <= 1'b0;
      modify_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      wr_cnt_r   <= '0;
      hit_r      <= 1'b0;
      stop_r     <= 1'b0;
      bdone_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_pos_r <= cfg_wdata;
        bank_r     <= 1'b0;
        total_r    <= CNT_W'(1);
      end

      if (cmd.load) begin
        skip_r     <= d_skip;
        modify_r   <= d_modify;
        pend_vld_r <= 1'b0;
        wr_cnt_r   <= '0;
        hit_r      <= 1'b0;
        stop_r     <= 1'b0;
        bdone_r    <= 1'b0;
      end

      if (push_en) begin
        pend_vld_r <= 1'b1;
        if (push_wr && wr_cnt_r != CNT_W'(MAX_RUNS + 1)) begin
          wr_cnt_r <= wr_cnt_r + CNT_W'(1);
        end
      end
      if (set_b_push) begin
        bdone_r <= 1'b1;
      end

      if (cmd.ph_a) begin
        if (op_r == OP_INSERT && !stop_r && ins_clamp) begin
          stop_r <= 1'b1;
        end
        if (!hit_r && ((op_r == OP_READ && read_hit) ||
                       (op_r == OP_INSERT && ins_shift && !stop_r))) begin
          hit_r <= 1'b1;
        end
      end

      if (cmd.finish && commit) begin
        bank_r  <= ~bank_r;
        total_r <= new_total;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_item.opcode;
      start_r   <= in_item.start_pos;
      hi_r      <= d_hi;
      shift_r   <= d_shift;
      top_r     <= d_top;
      len2_r    <= d_len2;
      val_r     <= in_item.new_value;
      mask_r    <= in_item.match_mask;
      cmp_r     <= in_item.match_compare;
      tail_r    <= d_tail;
      st_r      <= d_st;
      ent_idx_r <= '0;
      beg_r     <= '0;
      acc_r     <= '0;
      mc_r      <= '0;
      rv_r      <= '0;
      ri_r      <= '0;
    end

    if (push_en) begin
      pend_e_r <= push_e;
      pend_v_r <= push_v;
    end

    if (cmd.ph_a || cmd.ph_b) begin
      prod_r <= PRODW'(ent_v) * PRODW'(mul_len);
    end
    if ((cmd.ph_b || cmd.ph_c) && op_r == OP_SUM) begin
      acc_r <= acc_nxt;
    end

    if (cmd.ph_a) begin
      if (op_r == OP_COUNT && val_match) begin
        mc_r <= mc_r + COUNT_BITS'(len1);
      end
      if (!hit_r && ((op_r == OP_READ && read_hit) ||
                     (op_r == OP_INSERT && ins_shift && !stop_r))) begin
        rv_r <= ent_v;
        ri_r <= ent_idx_r;
      end
    end

    // advance to the next run
    if (cmd.ph_c) begin
      beg_r     <= ent_e1;
      ent_idx_r <= ent_idx_r + IDX_W'(1);
    end

    if (cmd.finish) begin
      out_r.read_value  <= rv_r;
      out_r.run_index   <= INDEX_BITS'(ri_r);
      out_r.range_sum   <= acc_r;
      out_r.match_count <= mc_r;
      out_r.status      <= fin_st;
    end
  end

  assign out_item = out_r;

endmodule

### design/run_length_range_table_core.sv
// Run-length table of up to MAX_RUNS runs over positions 0..last_position.
// A word on in_item is taken when start is high and busy is low; busy then
// stays high until the result is shown on out_item for exactly one cycle
// with out_strobe, in the same cycle that busy drops. The receiver must
// take the result in that cycle; nothing holds it. Every item that is not
// rejected walks the live run table through a single read port, taking
// each run through states PA, PB and PC; an item rejected up front (bad
// range, zero-length remove, unused opcode) skips the walk. Set, insert and
// remove rebuild the table into a second bank and swap banks at the end,
// so a rejected set leaves the table untouched. A write on cfg_we sets
// last_position and clears the table to one zero run in the same cycle;
// reset does the same with last_position at all ones, with no clearing pass.
`include "run_length_range_table_core_assert.svh"

module run_length_range_table_core import rlrt_pkg::*; #(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_item,
  output logic                out_strobe,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [POS_BITS-1:0] cfg_wdata
);

  rlrt_cmd_t cmd;
  rlrt_sts_t sts;

  rlrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  rlrt_dp #(
    .MAX_RUNS (MAX_RUNS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  `RLRT_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe longer than one cycle")
  `RLRT_ASSERT_NOW(a_done_strobe, $fell(busy), out_strobe, "busy dropped without a result")
  `RLRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

endmodule

### dv/tb_top.sv
module tb_top;
  import rlrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUNS       = MAX_RUNS_DEF;
  localparam int SLOW_ITEM  = 3 * RUNS + 3;
  localparam int MAX_CYCLES = 4_000_000;
  localparam int unsigned POS_TOP = (1 << POS_BITS) - 1;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_strobe;
  out_item_t           out_item;
  logic                cfg_we;
  logic [POS_BITS-1:0] cfg_wdata;

  run_length_range_table_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // shadow copy of the run table
  int unsigned tab_end [RUNS];
  int unsigned tab_val [RUNS];
  int unsigned tab_runs;
  int unsigned cur_last;
  int unsigned tmp_end [RUNS+2];
  int unsigned tmp_val [RUNS+2];
  int unsigned tmp_n;

  out_item_t   expected_words[$];
  int          err_count;
  longint      cycle_count;

  function automatic void tab_clear();
    for (int i = 0; i < RUNS; i++) begin
      tab_end[i] = 0;
      tab_val[i] = 0;
    end
    tab_end[0] = cur_last;
    tab_runs   = 1;
  endfunction

  function automatic int unsigned tab_find(int unsigned pos);
    for (int unsigned i = 0; i < tab_runs; i++)
      if (tab_end[i] >= pos) return i;
    return tab_runs - 1;
  endfunction

  function automatic int unsigned tab_begin(int unsigned i);
    return (i != 0) ? tab_end[i-1] + 1 : 0;
  endfunction

  function automatic void tmp_push(int unsigned e, int unsigned v);
    if (tmp_n > 0 && tmp_val[tmp_n-1] == v) begin
      tmp_end[tmp_n-1] = e;
    end else if (tmp_n < RUNS + 2) begin
      tmp_end[tmp_n] = e;
      tmp_val[tmp_n] = v;
      tmp_n++;
    end
  endfunction

  // rebuild with [s..e] painted v; return 0 and keep the table if it overflows
  function automatic bit tab_paint(int unsigned s, int unsigned e, int unsigned v);
    tmp_n = 0;
    for (int unsigned i = 0; i < tab_runs; i++)
      if (tab_begin(i) < s)
        tmp_push((tab_end[i] < s - 1) ? tab_end[i] : s - 1, tab_val[i]);
    tmp_push(e, v);
    for (int unsigned i = 0; i < tab_runs; i++)
      if (tab_end[i] > e) tmp_push(tab_end[i], tab_val[i]);
    if (tmp_n > RUNS) return 1'b0;
    for (int i = 0; i < RUNS; i++) begin
      tab_end[i] = (i < tmp_n) ? tmp_end[i] : 0;
      tab_val[i] = (i < tmp_n) ? tmp_val[i] : 0;
    end
    tab_runs = tmp_n;
    return 1'b1;
  endfunction

  function automatic void tab_drop(int unsigned at, int unsigned k);
    for (int unsigned i = at; i + k < tab_runs; i++) begin
      tab_end[i] = tab_end[i+k];
      tab_val[i] = tab_val[i+k];
    end
    tab_runs -= k;
    for (int unsigned i = tab_runs; i < RUNS; i++) begin
      tab_end[i] = 0;
      tab_val[i] = 0;
    end
  endfunction

  function automatic out_item_t table_apply(in_item_t w);
    out_item_t   r;
    int unsigned s, e, cnt, idx, top, rend, lo, hi;
    longint      acc;
    r   = '0;
    s   = 32'(w.start_pos);
    e   = 32'(w.end_pos);
    cnt = 32'(w.shift_count);
    acc = 0;
    case (w.opcode)
      OP_SET: begin
        if (s > e || e > cur_last) r.status = ST_BAD;
        else if (!tab_paint(s, e, 32'(w.new_value))) r.status = ST_FULL;
      end
      OP_READ: begin
        idx = tab_find(s);
        r.read_value = VALUE_BITS'(tab_val[idx]);
        r.run_index  = INDEX_BITS'(idx);
      end
      OP_INSERT: begin
        idx = tab_find(s);
        if (idx > 0 && tab_end[idx-1] + 1 == s) idx--;
        r.read_value = VALUE_BITS'(tab_val[idx]);
        r.run_index  = INDEX_BITS'(idx);
        for (int unsigned i = idx; i < tab_runs; i++) begin
          tab_end[i] += cnt;
          if (tab_end[i] >= cur_last) begin
            tab_end[i] = cur_last;
            tab_runs   = i + 1;
          end
        end
        for (int unsigned i = tab_runs; i < RUNS; i++) begin
          tab_end[i] = 0;
          tab_val[i] = 0;
        end
      end
      OP_REMOVE: begin
        if (s > cur_last) begin
          r.status = ST_BAD;
        end else if (cnt != 0) begin
          if (longint'(s) + longint'(cnt) - 64'd1 > longint'(cur_last))
            cnt = cur_last - s + 1;
          rend = s + cnt - 1;
          idx  = tab_find(s);
          if (rend > tab_end[idx]) begin
            void'(tab_paint(s, rend, tab_val[idx]));
            idx = tab_find(s);
          end
          if (tab_begin(idx) == s && tab_end[idx] == rend && idx + 1 < tab_runs) begin
            if (idx > 0 && tab_val[idx-1] == tab_val[idx+1]) begin
              idx--;
              tab_drop(idx, 2);
            end else begin
              tab_drop(idx, 1);
            end
          end
          for (int unsigned i = idx; i < tab_runs; i++) tab_end[i] -= cnt;
          tab_end[tab_runs-1] = cur_last;
        end
      end
      OP_SUM: begin
        if (s > e) begin
          r.status = ST_BAD;
        end else begin
          if (s <= cur_last) begin
            top = (e < cur_last) ? e : cur_last;
            lo  = s;
            for (idx = tab_find(s); idx < tab_runs && lo <= top; idx++) begin
              hi  = (tab_end[idx] < top) ? tab_end[idx] : top;
              acc += longint'(tab_val[idx]) * longint'(hi - lo + 1);
              if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
              lo = hi + 1;
            end
          end
          if (e > cur_last) begin
            lo  = (s > cur_last) ? s : cur_last + 1;
            acc += longint'(tab_val[tab_runs-1]) * longint'(e - lo + 1);
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
          end
          r.range_sum = acc[31:0];
        end
      end
      OP_COUNT: begin
        if (s > e) begin
          r.status = ST_BAD;
        end else if (s <= cur_last) begin
          top = (e < cur_last) ? e : cur_last;
          for (idx = tab_find(s); idx < tab_runs; idx++) begin
            lo = (tab_begin(idx) > s) ? tab_begin(idx) : s;
            hi = (tab_end[idx] < top) ? tab_end[idx] : top;
            if ((tab_val[idx] & 32'(w.match_mask)) == 32'(w.match_compare) && lo <= hi)
              acc += longint'(hi - lo + 1);
            if (tab_end[idx] >= top) break;
          end
          r.match_count = acc[COUNT_BITS-1:0];
        end
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  // directed rows: typed expectations only where obvious
  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } drow_t;

  drow_t dir_rows[$];

  function automatic in_item_t mk(logic [OP_BITS-1:0] op, int unsigned s, int unsigned e,
                                  int unsigned c, int unsigned v, int unsigned m,
                                  int unsigned k);
    in_item_t w;
    w.opcode        = op;
    w.start_pos     = POS_BITS'(s);
    w.end_pos       = POS_BITS'(e);
    w.shift_count   = POS_BITS'(c);
    w.new_value     = VALUE_BITS'(v);
    w.match_mask    = VALUE_BITS'(m);
    w.match_compare = VALUE_BITS'(k);
    return w;
  endfunction

  function automatic out_item_t res(int unsigned rv, longint sm, int unsigned mc,
                                    logic [STATUS_BITS-1:0] st);
    out_item_t r;
    r = '0;
    r.read_value  = VALUE_BITS'(rv);
    r.range_sum   = sm[31:0];
    r.match_count = COUNT_BITS'(mc);
    r.status      = st;
    return r;
  endfunction

  function automatic void add_row(in_item_t w, bit t, out_item_t x);
    drow_t d;
    d.word  = w;
    d.typed = t;
    d.want  = x;
    dir_rows.push_back(d);
  endfunction

  // one monitor for config, acceptance and results, all on the rising edge
  in_item_t  pending_dir;
  bit        pending_typed;
  out_item_t pending_want;

  always @(posedge clk) begin
    out_item_t got, want, calc;
    if (rst_n) begin
      if (out_strobe) begin
        got = out_item;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value exp %h got %h", $time, want.read_value, got.read_value);
            err_count++;
          end
          if (got.run_index !== want.run_index) begin
            $display("%0t: run_index exp %h got %h", $time, want.run_index, got.run_index);
            err_count++;
          end
          if (got.range_sum !== want.range_sum) begin
            $display("%0t: range_sum exp %h got %h", $time, want.range_sum, got.range_sum);
            err_count++;
          end
          if (got.match_count !== want.match_count) begin
            $display("%0t: match_count exp %h got %h", $time, want.match_count,
                     got.match_count);
            err_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status exp %h got %h", $time, want.status, got.status);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        calc = table_apply(in_item);
        expected_words.push_back(pending_typed ? pending_want : calc);
      end
      if (cfg_we) begin
        cur_last = 32'(cfg_wdata);
        tab_clear();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // hold start until the word is taken
  task automatic send_word(in_item_t w);
    start   <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task automatic write_last(int unsigned v);
    start <= 1'b0;
    while (expected_words.size() != 0 || busy) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= POS_BITS'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int unsigned pick_pos(int unsigned last);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return last;
      2: return $urandom_range(0, POS_TOP);
      3: return (last < POS_TOP) ? last + 1 : last;
      default: return $urandom_range(0, last);
    endcase
  endfunction

  function automatic in_item_t rand_word(int unsigned last);
    in_item_t    w;
    int unsigned a, b, t;
    a = pick_pos(last);
    b = pick_pos(last);
    // keep most ranges well formed
    if (a > b && $urandom_range(0, 7) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    w.start_pos = POS_BITS'(a);
    w.end_pos   = POS_BITS'(b);
    w.opcode    = OP_BITS'(($urandom_range(0, 40) == 0) ? $urandom_range(6, 7)
                                                        : $urandom_range(0, 5));
    case ($urandom_range(0, 5))
      0:       w.shift_count = POS_BITS'($urandom_range(0, POS_TOP));
      1:       w.shift_count = POS_BITS'(last);
      default: w.shift_count = POS_BITS'($urandom_range(0, 8));
    endcase
    w.new_value     = VALUE_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 'hFFFF)
                                                              : $urandom_range(0, 3));
    w.match_mask    = VALUE_BITS'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 'hFFFF)
                                                              : $urandom_range(0, 3));
    w.match_compare = ($urandom_range(0, 2) == 0)
                      ? VALUE_BITS'($urandom_range(0, 'hFFFF))
                      : (w.match_mask & VALUE_BITS'($urandom_range(0, 3)));
    return w;
  endfunction

  task automatic random_phase(int unsigned last, int n, bit idle);
    for (int i = 0; i < n; i++) begin
      send_word(rand_word(last));
      maybe_idle(idle);
    end
  endtask

  initial begin
    err_count     = 0;
    cycle_count   = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    pending_typed = 1'b0;
    pending_want  = '0;
    cur_last      = POS_TOP;
    tab_clear();

    add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, ST_OK));
    add_row(mk(OP_READ, POS_TOP, 0, 0, 0, 0, 0), 1, res(0, 0, 0, ST_OK));
    add_row(mk(OP_COUNT, 0, POS_TOP, 0, 0, 0, 0), 1, res(0, 0, 1 << 20, ST_OK));
    add_row(mk(OP_SUM, 0, POS_TOP, 0, 0, 0, 0), 1, res(0, 0, 0, ST_OK));
    add_row(mk(OP_SET, 5, 4, 0, 7, 0, 0), 1, res(0, 0, 0, ST_BAD));
    add_row(mk(OP_SUM, 9, 8, 0, 0, 0, 0), 1, res(0, 0, 0, ST_BAD));
    add_row(mk(OP_COUNT, 9, 8, 0, 0, 0, 0), 1, res(0, 0, 0, ST_BAD));
    add_row(mk(3'd6, 1, 2, 3, 4, 5, 6), 1, res(0, 0, 0, ST_BAD));
    add_row(mk(3'd7, POS_TOP, POS_TOP, POS_TOP, 'hFFFF, 'hFFFF, 'hFFFF), 1,
            res(0, 0, 0, ST_BAD));
    add_row(mk(OP_SET, 0, POS_TOP, 0, 'hFFFF, 0, 0), 1, res(0, 0, 0, ST_OK));
    add_row(mk(OP_SUM, 0, POS_TOP, 0, 0, 0, 0), 1, res(0, 64'hFFFF_FFFF, 0, ST_OK));
    add_row(mk(OP_COUNT, 0, POS_TOP, 0, 0, 'hFFFF, 'hFFFF), 1,
            res(0, 0, 1 << 20, ST_OK));
    add_row(mk(OP_SET, 100, 199, 0, 3, 0, 0), 0, '0);
    add_row(mk(OP_SET, 300, 300, 0, 3, 0, 0), 0, '0);
    add_row(mk(OP_READ, 150, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_INSERT, 100, 0, 10, 0, 0, 0), 0, '0);
    add_row(mk(OP_INSERT, POS_TOP, 0, 5, 0, 0, 0), 0, '0);
    add_row(mk(OP_REMOVE, 110, 0, 100, 0, 0, 0), 0, '0);
    add_row(mk(OP_REMOVE, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_REMOVE, 0, 0, 50, 0, 0, 0), 0, '0);
    add_row(mk(OP_REMOVE, POS_TOP - 3, 0, POS_TOP, 0, 0, 0), 0, '0);
    add_row(mk(OP_SUM, 0, 400, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_COUNT, 0, 400, 0, 0, 'h3, 'h3), 0, '0);
    add_row(mk(OP_INSERT, 0, 0, POS_TOP, 0, 0, 0), 0, '0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      pending_typed = dir_rows[i].typed;
      pending_want  = dir_rows[i].want;
      send_word(dir_rows[i].word);
      maybe_idle(1);
    end
    pending_typed = 1'b0;
    random_phase(POS_TOP, 130, 1);

    write_last(37);
    random_phase(37, 200, 1);
    write_last(0);
    random_phase(0, 80, 1);

    // fill the table to overflow, then work on the full table
    write_last(POS_TOP);
    for (int k = 0; k < 140; k++) begin
      send_word(mk(OP_SET, 2 * k + 1, 2 * k + 1, 0, 1 + (k % 2), 0, 0));
      maybe_idle(1);
    end
    random_phase(POS_TOP, 130, 1);

    write_last(255);
    random_phase(255, 200, 1);
    write_last(1000);
    random_phase(1000, 100, 0);

    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SLOW_ITEM) @(negedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
